[hw/rtl/tmg_pkg.sv]
// Shared widths, codes, tables and helpers of the torus mesh generator.
`default_nettype none

package tmg_pkg;

    localparam int IDX_W            = 9;
    localparam int SEG_W            = 9;
    localparam int RAD_W            = 16;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int POS_W            = 19;
    localparam int NRM_W            = 16;
    localparam int TEX_W            = 17;
    localparam int CW               = 32;
    localparam int ZW               = 33;
    localparam int PHASE_BITS       = 32;
    localparam int TEX_BITS         = 16;
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_STG       = 4;
    localparam int DIV_STG          = 8;
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int NRM_ONE          = 16384;

    localparam logic [RAD_W-1:0] OUTER_RADIUS_RST  = 16'd256;
    localparam logic [RAD_W-1:0] INNER_RADIUS_RST  = 16'd64;
    localparam logic [SEG_W-1:0] RING_SEGMENTS_RST = 9'd32;
    localparam logic [SEG_W-1:0] TUBE_SEGMENTS_RST = 9'd16;

    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING_SEGMENTS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TUBE_SEGMENTS = 2'd3;

    // CORDIC start value: 1/gain in Q1.30
    localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

    // atan(2^-k) in units of 2^-32 turn
    localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
    };

    typedef enum logic [1:0] {
        BEAT_VERTEX,
        BEAT_TRI_ABD,
        BEAT_TRI_BCD
    } beat_t;

    typedef struct packed {
        logic               tris;
        logic [POS_W-1:0]   d;
        logic [IDX_W:0]     w;
        logic [TEX_W-1:0]   tex_u;
        logic [TEX_W-1:0]   tex_v;
    } side_t;

    function automatic logic signed [NRM_W-1:0] clamp_nrm(input logic signed [NRM_W+1:0] v);
        logic signed [NRM_W-1:0] r;
        if (v > (NRM_W+2)'(NRM_ONE))
            r = NRM_W'(NRM_ONE);
        else if (v < -((NRM_W+2)'(NRM_ONE)))
            r = -(NRM_W'(NRM_ONE));
        else
            r = v[NRM_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tmg_ifs.sv]
// Valid/ready channel interfaces for grid points and mesh records.
`default_nettype none

interface tmg_grid_if;
    logic                        valid;
    logic                        ready;
    logic [tmg_pkg::IDX_W-1:0]   ring_index;
    logic [tmg_pkg::IDX_W-1:0]   tube_index;

    modport source (output valid, output ring_index, output tube_index, input ready);
    modport sink   (input valid, input ring_index, input tube_index, output ready);
endinterface

interface tmg_rec_if;
    logic                               valid;
    logic                               ready;
    logic                               is_triangle;
    logic                               last;
    logic signed [tmg_pkg::POS_W-1:0]   pos_x;
    logic signed [tmg_pkg::POS_W-1:0]   pos_y;
    logic signed [tmg_pkg::POS_W-1:0]   pos_z;
    logic signed [tmg_pkg::NRM_W-1:0]   nrm_x;
    logic signed [tmg_pkg::NRM_W-1:0]   nrm_y;
    logic signed [tmg_pkg::NRM_W-1:0]   nrm_z;
    logic [tmg_pkg::TEX_W-1:0]          tex_u;
    logic [tmg_pkg::TEX_W-1:0]          tex_v;

    modport source (output valid, output is_triangle, output last,
                    output pos_x, output pos_y, output pos_z,
                    output nrm_x, output nrm_y, output nrm_z,
                    output tex_u, output tex_v, input ready);
    modport sink   (input valid, input is_triangle, input last,
                    input pos_x, input pos_y, input pos_z,
                    input nrm_x, input nrm_y, input nrm_z,
                    input tex_u, input tex_v, output ready);
endinterface

`default_nettype wire

[hw/rtl/torus_mesh_generator.sv]
// Torus mesh generator: one grid point in, a vertex record and up to two triangle records out.
// A point passes the input register, dividers, CORDIC stages, M1 to M3 and the output register.
// Throughput: one grid point per cycle while no triangles follow and rec.ready is high; a point
//   on an inner corner sends one beat per record on the single result port and holds the pipeline.
// The pipeline advances as a whole; it holds while the output register still has beats.
// Reset clears the valid bits, the beat counter and restores the four config registers.
`default_nettype none

module torus_mesh_generator #(
    parameter int MAX_SEGMENTS = tmg_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tmg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tmg_pkg::CFG_W-1:0]         cfg_data,
    tmg_grid_if.sink                               grid,
    tmg_rec_if.source                              rec
);

    localparam int SW    = tmg_pkg::SEG_W;
    localparam int IW    = tmg_pkg::IDX_W;
    localparam int RW    = tmg_pkg::RAD_W;
    localparam int PW    = tmg_pkg::POS_W;
    localparam int NW    = tmg_pkg::NRM_W;
    localparam int TW    = tmg_pkg::TEX_W;
    localparam int CW    = tmg_pkg::CW;
    localparam int DSTG  = tmg_pkg::DIV_STG;
    localparam int NP    = DSTG + tmg_pkg::CORDIC_STG + 3;

    // config
    logic [RW-1:0] outer_radius_reg;
    logic [RW-1:0] inner_radius_reg;
    logic [SW-1:0] ring_segments_reg;
    logic [SW-1:0] tube_segments_reg;
    logic [SW-1:0] ring_eff;
    logic [SW-1:0] tube_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_radius_reg  <= tmg_pkg::OUTER_RADIUS_RST;
            inner_radius_reg  <= tmg_pkg::INNER_RADIUS_RST;
            ring_segments_reg <= tmg_pkg::RING_SEGMENTS_RST;
            tube_segments_reg <= tmg_pkg::TUBE_SEGMENTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmg_pkg::REG_OUTER_RADIUS:  outer_radius_reg  <= cfg_data[RW-1:0];
                tmg_pkg::REG_INNER_RADIUS:  inner_radius_reg  <= cfg_data[RW-1:0];
                tmg_pkg::REG_RING_SEGMENTS: ring_segments_reg <= cfg_data[SW-1:0];
                tmg_pkg::REG_TUBE_SEGMENTS: tube_segments_reg <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [SW-1:0] eff_seg(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        if (s == '0)
            r = SW'(1);
        else if ({4'b0, s} > (SW+4)'(MAX_SEGMENTS))
            r = SW'(MAX_SEGMENTS);
        else
            r = s;
        return r;
    endfunction

    assign ring_eff = eff_seg(ring_segments_reg);
    assign tube_eff = eff_seg(tube_segments_reg);

    // pipeline control
    logic          adv;
    logic          ov_reg;
    tmg_pkg::beat_t beat_reg;
    logic          o_tris_reg;
    logic          out_last;

    assign out_last   = !o_tris_reg || (beat_reg == tmg_pkg::BEAT_TRI_BCD);
    assign adv        = !ov_reg || (rec.ready && out_last);
    assign grid.ready = adv;

    // input stage: clamp the indices
    logic          s0_valid_reg;
    logic [IW-1:0] s0_j_reg;
    logic [IW-1:0] s0_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= grid.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_j_reg <= (grid.ring_index > ring_eff) ? ring_eff : grid.ring_index;
            s0_i_reg <= (grid.tube_index > tube_eff) ? tube_eff : grid.tube_index;
        end
    end

    // sideband that travels with each item
    tmg_pkg::side_t side0;
    tmg_pkg::side_t sd_tex;
    tmg_pkg::side_t sd_reg [NP];
    logic [NP-1:0]  pv_reg;

    always_comb
    begin
        side0       = '0;
        side0.tris  = (s0_j_reg != '0) && (s0_i_reg != '0);
        side0.w     = {1'b0, tube_eff} + (IW+1)'(1);
        side0.d     = PW'(side0.w) * PW'(s0_j_reg) + PW'(s0_i_reg);
    end

    logic [tmg_pkg::PHASE_BITS:0] ring_q;
    logic [tmg_pkg::PHASE_BITS:0] tube_q;
    logic [tmg_pkg::TEX_BITS:0]   texv_q;
    logic [tmg_pkg::TEX_BITS:0]   texu_q;

    tmg_div #(.QBITS(tmg_pkg::PHASE_BITS), .NSTG(DSTG)) u_div_ring (
        .clk(clk), .en(adv), .idx(s0_j_reg), .seg(ring_eff), .quo(ring_q)
    );
    tmg_div #(.QBITS(tmg_pkg::PHASE_BITS), .NSTG(DSTG)) u_div_tube (
        .clk(clk), .en(adv), .idx(s0_i_reg), .seg(tube_eff), .quo(tube_q)
    );
    tmg_div #(.QBITS(tmg_pkg::TEX_BITS), .NSTG(DSTG)) u_div_texv (
        .clk(clk), .en(adv), .idx(s0_j_reg), .seg(ring_eff), .quo(texv_q)
    );
    tmg_div #(.QBITS(tmg_pkg::TEX_BITS), .NSTG(DSTG)) u_div_texu (
        .clk(clk), .en(adv), .idx(s0_i_reg), .seg(tube_eff), .quo(texu_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= {pv_reg[NP-2:0], s0_valid_reg};
    end

    // merge the texture quotients into the sideband as they leave the dividers
    always_comb
    begin
        sd_tex       = sd_reg[DSTG-1];
        sd_tex.tex_u = TW'(texu_q);
        sd_tex.tex_v = TW'(texv_q);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= side0;
            for (int k = 1; k < NP; k++)
            begin
                if (k == DSTG)
                    sd_reg[k] <= sd_tex;
                else
                    sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // angles
    logic signed [CW-1:0] ct, st, cp, sp;

    tmg_cordic u_cor_ring (
        .clk(clk), .en(adv), .phase(ring_q[tmg_pkg::PHASE_BITS-1:0]), .cos_o(ct), .sin_o(st)
    );
    tmg_cordic u_cor_tube (
        .clk(clk), .en(adv), .phase(tube_q[tmg_pkg::PHASE_BITS-1:0]), .cos_o(cp), .sin_o(sp)
    );

    // M1: products of the angles, and of the inner radius with the tube angle
    logic signed [48:0]   m1_rcp_reg;
    logic signed [48:0]   m1_rsp_reg;
    logic signed [63:0]   m1_ncx_reg;
    logic signed [63:0]   m1_ncz_reg;
    logic signed [CW-1:0] m1_ct_reg;
    logic signed [CW-1:0] m1_st_reg;
    logic signed [CW-1:0] m1_sp_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_rcp_reg <= $signed({1'b0, inner_radius_reg}) * cp;
            m1_rsp_reg <= $signed({1'b0, inner_radius_reg}) * sp;
            m1_ncx_reg <= cp * ct;
            m1_ncz_reg <= cp * st;
            m1_ct_reg  <= ct;
            m1_st_reg  <= st;
            m1_sp_reg  <= sp;
        end
    end

    // M2: radius sum and the narrowed fields
    logic signed [50:0]   sum_full;
    logic signed [49:0]   py_full;
    logic signed [63:0]   nx_full;
    logic signed [63:0]   nz_full;
    logic signed [32:0]   ny_full;
    logic signed [28:0]   m2_sum_reg;
    logic signed [PW-1:0] m2_py_reg;
    logic signed [NW-1:0] m2_nx_reg;
    logic signed [NW-1:0] m2_ny_reg;
    logic signed [NW-1:0] m2_nz_reg;
    logic signed [CW-1:0] m2_ct_reg;
    logic signed [CW-1:0] m2_st_reg;

    assign sum_full = $signed({5'b0, outer_radius_reg, 30'b0}) + 51'(m1_rcp_reg)
                      + 51'sd2097152;
    assign py_full  = 50'(m1_rsp_reg) + 50'sd536870912;
    assign nx_full  = m1_ncx_reg + 64'sd35184372088832;
    assign nz_full  = m1_ncz_reg + 64'sd35184372088832;
    assign ny_full  = 33'(m1_sp_reg) + 33'sd32768;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_sum_reg <= sum_full[50:22];
            m2_py_reg  <= py_full[48:30];
            m2_nx_reg  <= tmg_pkg::clamp_nrm($signed(nx_full[63:46]));
            m2_nz_reg  <= tmg_pkg::clamp_nrm($signed(nz_full[63:46]));
            m2_ny_reg  <= tmg_pkg::clamp_nrm((NW+2)'($signed(ny_full[32:16])));
            m2_ct_reg  <= m1_ct_reg;
            m2_st_reg  <= m1_st_reg;
        end
    end

    // M3: position products
    logic signed [60:0]   m3_px_reg;
    logic signed [60:0]   m3_pz_reg;
    logic signed [PW-1:0] m3_py_reg;
    logic signed [NW-1:0] m3_nx_reg;
    logic signed [NW-1:0] m3_ny_reg;
    logic signed [NW-1:0] m3_nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_px_reg <= m2_sum_reg * m2_ct_reg;
            m3_pz_reg <= m2_sum_reg * m2_st_reg;
            m3_py_reg <= m2_py_reg;
            m3_nx_reg <= m2_nx_reg;
            m3_ny_reg <= m2_ny_reg;
            m3_nz_reg <= m2_nz_reg;
        end
    end

    // output register and record sequencer
    logic signed [60:0]   px_full;
    logic signed [60:0]   pz_full;
    logic signed [PW-1:0] o_px_reg;
    logic signed [PW-1:0] o_py_reg;
    logic signed [PW-1:0] o_pz_reg;
    logic signed [NW-1:0] o_nx_reg;
    logic signed [NW-1:0] o_ny_reg;
    logic signed [NW-1:0] o_nz_reg;
    logic [TW-1:0]        o_tu_reg;
    logic [TW-1:0]        o_tv_reg;
    logic [PW-1:0]        o_d_reg;
    logic [IW:0]          o_w_reg;

    assign px_full = m3_px_reg + 61'sd137438953472;
    assign pz_full = m3_pz_reg + 61'sd137438953472;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            beat_reg   <= tmg_pkg::BEAT_VERTEX;
            o_tris_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg     <= pv_reg[NP-1];
            beat_reg   <= tmg_pkg::BEAT_VERTEX;
            o_tris_reg <= sd_reg[NP-1].tris;
        end
        else if (rec.ready)
        begin
            // ov_reg is high here; step to the next triangle beat
            case (beat_reg)
                tmg_pkg::BEAT_VERTEX:  beat_reg <= tmg_pkg::BEAT_TRI_ABD;
                tmg_pkg::BEAT_TRI_ABD: beat_reg <= tmg_pkg::BEAT_TRI_BCD;
                default:               beat_reg <= tmg_pkg::BEAT_VERTEX;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_px_reg <= px_full[56:38];
            o_pz_reg <= pz_full[56:38];
            o_py_reg <= m3_py_reg;
            o_nx_reg <= m3_nx_reg;
            o_ny_reg <= m3_ny_reg;
            o_nz_reg <= m3_nz_reg;
            o_tu_reg <= sd_reg[NP-1].tex_u;
            o_tv_reg <= sd_reg[NP-1].tex_v;
            o_d_reg  <= sd_reg[NP-1].d;
            o_w_reg  <= sd_reg[NP-1].w;
        end
    end

    logic [PW-1:0] ca, cb, cc;

    assign ca = o_d_reg - PW'(1);
    assign cc = o_d_reg - PW'(o_w_reg);
    assign cb = cc - PW'(1);

    always_comb
    begin
        rec.valid       = ov_reg;
        rec.last        = out_last;
        rec.is_triangle = 1'b1;
        rec.pos_x       = '0;
        rec.pos_y       = '0;
        rec.pos_z       = '0;
        rec.nrm_x       = '0;
        rec.nrm_y       = '0;
        rec.nrm_z       = '0;
        rec.tex_u       = '0;
        rec.tex_v       = '0;
        case (beat_reg)
            tmg_pkg::BEAT_VERTEX:
            begin
                rec.is_triangle = 1'b0;
                rec.pos_x       = o_px_reg;
                rec.pos_y       = o_py_reg;
                rec.pos_z       = o_pz_reg;
                rec.nrm_x       = o_nx_reg;
                rec.nrm_y       = o_ny_reg;
                rec.nrm_z       = o_nz_reg;
                rec.tex_u       = o_tu_reg;
                rec.tex_v       = o_tv_reg;
            end
            tmg_pkg::BEAT_TRI_ABD:
            begin
                rec.pos_x = $signed(ca);
                rec.pos_y = $signed(cb);
                rec.pos_z = $signed(o_d_reg);
            end
            tmg_pkg::BEAT_TRI_BCD:
            begin
                rec.pos_x = $signed(cb);
                rec.pos_y = $signed(cc);
                rec.pos_z = $signed(o_d_reg);
            end
            default:
            begin
                rec.is_triangle = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/tmg_div.sv]
// Pipelined restoring divider: round(idx * 2^QBITS / seg), ceil(QBITS/NSTG) quotient bits per stage.
`default_nettype none

module tmg_div #(
    parameter int QBITS = tmg_pkg::PHASE_BITS,
    parameter int NSTG  = tmg_pkg::DIV_STG
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [tmg_pkg::IDX_W-1:0]     idx,
    input  wire logic [tmg_pkg::SEG_W-1:0]     seg,
    output logic      [QBITS:0]                quo
);

    localparam int SW  = tmg_pkg::SEG_W;
    localparam int SPS = (QBITS + NSTG - 1) / NSTG;

    logic [SW-1:0]  rem_reg [NSTG];
    logic [QBITS:0] q_reg   [NSTG];
    logic [QBITS-1:0] half;

    // low dividend bits carry the rounding offset seg/2
    assign half = QBITS'(seg >> 1);

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [SW-1:0]  rin;
        logic [QBITS:0] qin;
        logic [SW-1:0]  rout;
        logic [QBITS:0] qout;

        if (s == 0) begin : g_init
            logic eq;
            // idx never exceeds seg, so the integer part is a single bit
            assign eq  = (idx == seg);
            assign rin = eq ? '0 : idx;
            assign qin = {eq, {QBITS{1'b0}}};
        end else begin : g_link
            assign rin = rem_reg[s-1];
            assign qin = q_reg[s-1];
        end

        always_comb
        begin
            logic [SW:0] r2;
            int          g;
            r2   = '0;
            g    = 0;
            rout = rin;
            qout = qin;
            for (int t = 0; t < SPS; t++)
            begin
                g = s * SPS + t;
                if (g < QBITS)
                begin
                    r2 = {rout, half[QBITS-1-g]};
                    if (r2 >= {1'b0, seg})
                    begin
                        rout            = SW'(r2 - {1'b0, seg});
                        qout[QBITS-1-g] = 1'b1;
                    end
                    else
                    begin
                        rout = r2[SW-1:0];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rout;
                q_reg[s]   <= qout;
            end
        end
    end

    assign quo = q_reg[NSTG-1];

endmodule

`default_nettype wire

[hw/rtl/tmg_cordic.sv]
// Pipelined 16-step CORDIC: cosine and sine in Q1.30 of a 32-bit turn phase.
`default_nettype none

module tmg_cordic (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic        [tmg_pkg::PHASE_BITS-1:0] phase,
    output logic signed      [tmg_pkg::CW-1:0]     cos_o,
    output logic signed      [tmg_pkg::CW-1:0]     sin_o
);

    localparam int CW   = tmg_pkg::CW;
    localparam int ZW   = tmg_pkg::ZW;
    localparam int NSTG = tmg_pkg::CORDIC_STG;
    localparam int SPS  = tmg_pkg::CORDIC_STEPS / NSTG;

    logic signed [CW-1:0] x_reg    [NSTG];
    logic signed [CW-1:0] y_reg    [NSTG];
    logic signed [ZW-1:0] z_reg    [NSTG];
    logic                 flip_reg [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic signed [CW-1:0] xin;
        logic signed [CW-1:0] yin;
        logic signed [ZW-1:0] zin;
        logic                 fin;
        logic signed [CW-1:0] xout;
        logic signed [CW-1:0] yout;
        logic signed [ZW-1:0] zout;

        if (s == 0) begin : g_init
            logic [tmg_pkg::PHASE_BITS-1:0] ph;
            // second and third quadrant: rotate by half a turn and negate at the end
            assign fin = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
            assign ph  = fin ? {~phase[31], phase[30:0]} : phase;
            assign zin = ZW'($signed(ph));
            assign xin = tmg_pkg::CORDIC_X0;
            assign yin = '0;
        end else begin : g_link
            assign xin = x_reg[s-1];
            assign yin = y_reg[s-1];
            assign zin = z_reg[s-1];
            assign fin = flip_reg[s-1];
        end

        always_comb
        begin
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] y;
            logic signed [CW-1:0] nx;
            logic signed [ZW-1:0] z;
            int                   k;
            x  = xin;
            y  = yin;
            z  = zin;
            nx = '0;
            k  = 0;
            for (int t = 0; t < SPS; t++)
            begin
                k = s * SPS + t;
                if (z >= 0)
                begin
                    nx = x - (y >>> k);
                    y  = y + (x >>> k);
                    z  = z - tmg_pkg::ATAN_TURN[k];
                end
                else
                begin
                    nx = x + (y >>> k);
                    y  = y - (x >>> k);
                    z  = z + tmg_pkg::ATAN_TURN[k];
                end
                x = nx;
            end
            if ((s == NSTG - 1) && fin)
            begin
                x = -x;
                y = -y;
            end
            xout = x;
            yout = y;
            zout = z;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= xout;
                y_reg[s]    <= yout;
                z_reg[s]    <= zout;
                flip_reg[s] <= fin;
            end
        end
    end

    assign cos_o = x_reg[NSTG-1];
    assign sin_o = y_reg[NSTG-1];

endmodule

`default_nettype wire

[hw/rtl/tmg_checker.sv]
// Port-level checks on the record channel of the torus mesh generator, and their bind.
`default_nettype none

module tmg_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              valid,
    input wire logic                              ready,
    input wire logic                              is_triangle,
    input wire logic                              last,
    input wire logic signed [tmg_pkg::POS_W-1:0]  pos_x,
    input wire logic signed [tmg_pkg::POS_W-1:0]  pos_y,
    input wire logic signed [tmg_pkg::POS_W-1:0]  pos_z,
    input wire logic signed [tmg_pkg::NRM_W-1:0]  nrm_x,
    input wire logic signed [tmg_pkg::NRM_W-1:0]  nrm_y,
    input wire logic signed [tmg_pkg::NRM_W-1:0]  nrm_z,
    input wire logic [tmg_pkg::TEX_W-1:0]         tex_u,
    input wire logic [tmg_pkg::TEX_W-1:0]         tex_v
);

    // triangles carry no normal or texture
    a_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_triangle |->
            nrm_x == '0 && nrm_y == '0 && nrm_z == '0 && tex_u == '0 && tex_v == '0)
        else $error("triangle record with nonzero normal or texture");

    // corners of one quad: first triangle has d = a + 1, second c = b + 1
    a_tri_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_triangle |->
            (last ? (pos_y == pos_x + 19'sd1) : (pos_z == pos_x + 19'sd1)))
        else $error("triangle corners do not form a grid quad");

    // a vertex that is not last is followed at once by the first triangle
    a_vertex_then_tri: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !is_triangle && !last |=> valid && is_triangle && !last)
        else $error("missing first triangle after vertex");

    a_tri_then_tri: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && is_triangle && !last |=> valid && is_triangle && last)
        else $error("missing second triangle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({is_triangle, last, pos_x, pos_y, pos_z,
                                               nrm_x, nrm_y, nrm_z, tex_u, tex_v}))
        else $error("stalled record beat changed");

endmodule

bind torus_mesh_generator tmg_checker u_tmg_checker (
    .clk(clk),
    .rst_n(rst_n),
    .valid(rec.valid),
    .ready(rec.ready),
    .is_triangle(rec.is_triangle),
    .last(rec.last),
    .pos_x(rec.pos_x),
    .pos_y(rec.pos_y),
    .pos_z(rec.pos_z),
    .nrm_x(rec.nrm_x),
    .nrm_y(rec.nrm_y),
    .nrm_z(rec.nrm_z),
    .tex_u(rec.tex_u),
    .tex_v(rec.tex_v)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench of the torus mesh generator: grid points in, mesh records checked.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                      is_triangle;
        logic                      last;
        logic [tmg_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
        logic [tmg_pkg::NRM_W-1:0] nrm_x, nrm_y, nrm_z;
        logic [tmg_pkg::TEX_W-1:0] tex_u, tex_v;
    } mesh_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [tmg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tmg_pkg::CFG_W-1:0] cfg_data = '0;

    tmg_grid_if grid ();
    tmg_rec_if  rec ();

    torus_mesh_generator i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .grid(grid.sink), .rec(rec.source)
    );

    longint unsigned outer_r, inner_r, ring_seg, tube_seg;
    mesh_rec_t expected_recs[$];
    int errors = 0;
    longint cycles = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned seg_used(longint unsigned s);
        if (s == 0) return 1;
        if (s > tmg_pkg::MAX_SEGMENTS_DEF) return tmg_pkg::MAX_SEGMENTS_DEF;
        return s;
    endfunction

    // append one expected record at the tail
    task automatic queue_rec(input mesh_rec_t r);
        expected_recs = {expected_recs, r};
    endtask

    task automatic sincos_turn(input logic [31:0] ph, output longint c, output longint s);
        longint x, y, z, nx;
        logic flip;
        x = 652032874;
        y = 0;
        flip = (ph[31:30] == 2'd1 || ph[31:30] == 2'd2);
        if (flip) ph = ph - 32'h8000_0000;
        z = longint'($signed(ph));
        for (int k = 0; k < tmg_pkg::CORDIC_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - fshift(y, k);
                y = y + fshift(x, k);
                z = z - longint'(tmg_pkg::ATAN_TURN[k]);
            end else begin
                nx = x + fshift(y, k);
                y = y - fshift(x, k);
                z = z + longint'(tmg_pkg::ATAN_TURN[k]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint nclamp(longint v);
        if (v > tmg_pkg::NRM_ONE) return tmg_pkg::NRM_ONE;
        if (v < -tmg_pkg::NRM_ONE) return -tmg_pkg::NRM_ONE;
        return v;
    endfunction

    task automatic predict_point(input longint unsigned jin, input longint unsigned iin);
        longint unsigned rs, ts, j, i;
        longint ct, st, cp, sp, sum, w, a, b, c, d;
        mesh_rec_t v, t;
        logic [31:0] pj, pi;
        rs = seg_used(ring_seg);
        ts = seg_used(tube_seg);
        j = (jin > rs) ? rs : jin;
        i = (iin > ts) ? ts : iin;
        pj = 32'(((j << 32) + (rs >> 1)) / rs);
        pi = 32'(((i << 32) + (ts >> 1)) / ts);
        sincos_turn(pj, ct, st);
        sincos_turn(pi, cp, sp);
        sum = rshift((longint'(outer_r) << 30) + longint'(inner_r) * cp, 22);
        v.is_triangle = 1'b0;
        v.last = !(j >= 1 && i >= 1);
        v.pos_x = tmg_pkg::POS_W'(rshift(sum * ct, 38));
        v.pos_y = tmg_pkg::POS_W'(rshift(longint'(inner_r) * sp, 30));
        v.pos_z = tmg_pkg::POS_W'(rshift(sum * st, 38));
        v.nrm_x = tmg_pkg::NRM_W'(nclamp(rshift(cp * ct, 46)));
        v.nrm_y = tmg_pkg::NRM_W'(nclamp(rshift(sp, 16)));
        v.nrm_z = tmg_pkg::NRM_W'(nclamp(rshift(cp * st, 46)));
        v.tex_u = tmg_pkg::TEX_W'(((i << 16) + (ts >> 1)) / ts);
        v.tex_v = tmg_pkg::TEX_W'(((j << 16) + (rs >> 1)) / rs);
        queue_rec(v);
        if (v.last) return;
        w = longint'(ts) + 1;
        a = w * longint'(j) + longint'(i) - 1;
        b = w * (longint'(j) - 1) + longint'(i) - 1;
        c = b + 1;
        d = a + 1;
        t = '{default: '0};
        t.is_triangle = 1'b1;
        t.pos_x = tmg_pkg::POS_W'(a);
        t.pos_y = tmg_pkg::POS_W'(b);
        t.pos_z = tmg_pkg::POS_W'(d);
        queue_rec(t);
        t.last = 1'b1;
        t.pos_x = tmg_pkg::POS_W'(b);
        t.pos_y = tmg_pkg::POS_W'(c);
        queue_rec(t);
    endtask

    // receiver: random stall per record, compare each beat with the oldest expectation
    initial begin
        int gap;
        mesh_rec_t e;
        rec.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            rec.ready = 1'b0;
            repeat (gap) @(negedge clk);
            rec.ready = 1'b1;
            do @(posedge clk); while (!rec.valid);
            if (expected_recs.size() == 0) begin
                $error("record with nothing expected");
                errors++;
            end else begin
                e = expected_recs.pop_front();
                if (rec.is_triangle !== e.is_triangle) begin
                    $error("is_triangle exp %0d got %0d", e.is_triangle, rec.is_triangle);
                    errors++;
                end
                if (rec.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, rec.last); errors++;
                end
                if (rec.pos_x !== e.pos_x) begin
                    $error("pos_x exp %0h got %0h", e.pos_x, rec.pos_x); errors++;
                end
                if (rec.pos_y !== e.pos_y) begin
                    $error("pos_y exp %0h got %0h", e.pos_y, rec.pos_y); errors++;
                end
                if (rec.pos_z !== e.pos_z) begin
                    $error("pos_z exp %0h got %0h", e.pos_z, rec.pos_z); errors++;
                end
                if (rec.nrm_x !== e.nrm_x) begin
                    $error("nrm_x exp %0h got %0h", e.nrm_x, rec.nrm_x); errors++;
                end
                if (rec.nrm_y !== e.nrm_y) begin
                    $error("nrm_y exp %0h got %0h", e.nrm_y, rec.nrm_y); errors++;
                end
                if (rec.nrm_z !== e.nrm_z) begin
                    $error("nrm_z exp %0h got %0h", e.nrm_z, rec.nrm_z); errors++;
                end
                if (rec.tex_u !== e.tex_u) begin
                    $error("tex_u exp %0h got %0h", e.tex_u, rec.tex_u); errors++;
                end
                if (rec.tex_v !== e.tex_v) begin
                    $error("tex_v exp %0h got %0h", e.tex_v, rec.tex_v); errors++;
                end
            end
        end
    end

    task automatic send_point(input int j, input int i);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge clk);
        grid.valid = 1'b1;
        grid.ring_index = tmg_pkg::IDX_W'(j);
        grid.tube_index = tmg_pkg::IDX_W'(i);
        do @(posedge clk); while (!grid.ready);
        predict_point(j, i);
        @(negedge clk);
        grid.valid = 1'b0;
    endtask

    // drain all records plus the pipeline latency before touching registers
    task automatic wait_idle();
        while (expected_recs.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [tmg_pkg::CFG_IDX_W-1:0] idx, input int val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = tmg_pkg::CFG_W'(val);
        case (idx)
            tmg_pkg::REG_OUTER_RADIUS:  outer_r = val & 16'hFFFF;
            tmg_pkg::REG_INNER_RADIUS:  inner_r = val & 16'hFFFF;
            tmg_pkg::REG_RING_SEGMENTS: ring_seg = val & 9'h1FF;
            default:                    tube_seg = val & 9'h1FF;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_point(0, 0);
        send_point(1, 1);
        send_point(32, 16);
        send_point(8, 4);
        send_point(511, 511);
        send_point(16, 8);
    endtask

    task automatic test_extremes();
        write_reg(tmg_pkg::REG_OUTER_RADIUS, 65535);
        write_reg(tmg_pkg::REG_INNER_RADIUS, 65535);
        write_reg(tmg_pkg::REG_RING_SEGMENTS, 256);
        write_reg(tmg_pkg::REG_TUBE_SEGMENTS, 256);
        send_point(0, 0);
        send_point(256, 256);
        send_point(64, 128);
        send_point(255, 1);
        send_point(300, 200);
        write_reg(tmg_pkg::REG_INNER_RADIUS, 0);
        write_reg(tmg_pkg::REG_OUTER_RADIUS, 0);
        send_point(3, 7);
        send_point(128, 64);
        // zero and oversized segment registers
        write_reg(tmg_pkg::REG_RING_SEGMENTS, 0);
        write_reg(tmg_pkg::REG_TUBE_SEGMENTS, 511);
        send_point(1, 300);
        send_point(0, 5);
        send_point(2, 2);
        write_reg(tmg_pkg::REG_RING_SEGMENTS, 1);
        write_reg(tmg_pkg::REG_TUBE_SEGMENTS, 1);
        send_point(1, 1);
        send_point(0, 1);
    endtask

    task automatic test_random(input int n);
        int j, i;
        for (int k = 0; k < n; k++) begin
            if (k % 75 == 0) begin
                write_reg(tmg_pkg::REG_OUTER_RADIUS, $urandom_range(0, 65535));
                write_reg(tmg_pkg::REG_INNER_RADIUS, $urandom_range(0, 65535));
                write_reg(tmg_pkg::REG_RING_SEGMENTS, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 511) : $urandom_range(1, 64));
                write_reg(tmg_pkg::REG_TUBE_SEGMENTS, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 511) : $urandom_range(1, 64));
            end
            if ($urandom_range(0, 4) == 0) begin
                j = $urandom_range(0, 511);
                i = $urandom_range(0, 511);
            end else begin
                j = $urandom_range(0, int'(seg_used(ring_seg)));
                i = $urandom_range(0, int'(seg_used(tube_seg)));
            end
            send_point(j, i);
        end
    endtask

    initial begin
        outer_r = tmg_pkg::OUTER_RADIUS_RST;
        inner_r = tmg_pkg::INNER_RADIUS_RST;
        ring_seg = tmg_pkg::RING_SEGMENTS_RST;
        tube_seg = tmg_pkg::TUBE_SEGMENTS_RST;
        grid.valid = 1'b0;
        grid.ring_index = '0;
        grid.tube_index = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_extremes();
        test_random(450);
        wait_idle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

`default_nettype wire
